### rtl/bmmpq_pkg.sv
// shared constants and types for the bucketed min/max priority queue
package bmmpq_pkg;

  localparam int unsigned NUM_COSTS   = 64;
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned COST_WIDTH  = 7;
  localparam int unsigned IDX_WIDTH   = $clog2(NUM_COSTS);
  localparam logic [IDX_WIDTH-1:0] LAST_IDX = IDX_WIDTH'(NUM_COSTS - 1);

  typedef enum logic {
    OP_ADD    = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  // per-cycle control fanned out to every bucket cell
  typedef struct packed {
    logic low_first;
    logic scan_en;
  } cell_ctrl_t;

endpackage

### rtl/bmmpq_cell.sv
// one bucket cell: occupancy counter plus the search token stage of the chain
module bmmpq_cell
  import bmmpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       add_i,
  input  logic       tok_lo_i,
  input  logic       tok_hi_i,
  output logic       tok_o,
  output logic       hit_o
);

  logic [COUNT_WIDTH-1:0] count_q, count_d;
  logic                   tok_q, tok_d;
  logic                   tok_in;

  // token arrives from the neighbor on the side the scan starts from
  assign tok_in = ctrl_i.scan_en & (ctrl_i.low_first ? tok_lo_i : tok_hi_i);
  assign hit_o  = tok_in & (count_q != '0);
  assign tok_o  = tok_q;

  always_comb begin
    count_d = count_q;
    if (hit_o) begin
      count_d = count_q - COUNT_WIDTH'(1);
    end else if (add_i && (count_q != '1)) begin
      count_d = count_q + COUNT_WIDTH'(1);
    end
    tok_d = tok_in & ~hit_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      tok_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      tok_q   <= tok_d;
    end
  end

endmodule

### rtl/bmmpq_ctrl.sv
// remove sequencer: injects the search token, tracks its position, drives results
module bmmpq_ctrl
  import bmmpq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  logic                  operation_i,
  input  logic                  low_first_i,
  input  logic                  any_hit_i,
  output logic                  busy,
  output logic                  inject_o,
  output logic                  result_valid_o,
  output logic                  found_o,
  output logic [COST_WIDTH-1:0] removed_cost_o
);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  state_e                 state_q;
  logic                   inj_q;
  logic                   valid_q;
  logic                   found_q;
  logic [COST_WIDTH-1:0]  cost_q;
  logic [IDX_WIDTH-1:0]   pos_q;
  logic [IDX_WIDTH-1:0]   end_pos;

  assign busy           = (state_q == ST_SCAN);
  assign inject_o       = inj_q;
  assign result_valid_o = valid_q;
  assign found_o        = found_q;
  assign removed_cost_o = cost_q;
  assign end_pos        = low_first_i ? LAST_IDX : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      inj_q   <= 1'b0;
      valid_q <= 1'b0;
      found_q <= 1'b0;
      cost_q  <= '0;
      pos_q   <= '0;
    end else begin
      inj_q   <= 1'b0;
      valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start && (operation_i == OP_REMOVE)) begin
            state_q <= ST_SCAN;
            inj_q   <= 1'b1;
            pos_q   <= low_first_i ? '0 : LAST_IDX;
          end
        end
        ST_SCAN: begin
          if (any_hit_i) begin
            valid_q <= 1'b1;
            found_q <= 1'b1;
            cost_q  <= COST_WIDTH'(pos_q) + COST_WIDTH'(1);
            state_q <= ST_IDLE;
          end else if (pos_q == end_pos) begin
            valid_q <= 1'b1;
            found_q <= 1'b0;
            cost_q  <= '0;
            state_q <= ST_IDLE;
          end else if (low_first_i) begin
            pos_q <= pos_q + IDX_WIDTH'(1);
          end else begin
            pos_q <= pos_q - IDX_WIDTH'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_SCAN))
    else $error("result strobe without a scan in progress");

  a_empty_cost_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !found_o) |-> (removed_cost_o == '0))
    else $error("not-found result carries a cost");

  a_hit_only_scanning: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_hit_i |-> busy)
    else $error("bucket hit outside a scan");
`endif

endmodule

### rtl/bucket_min_max_priority_queue.sv
// top level: policy register, add decode, chain of bucket cells and sequencer
// An add (operation 0) leaves busy low, so adds can follow back to back; a
// cost of 0 or above NUM_COSTS is dropped without a result. A remove
// (operation 1) sends a search token along the chain of NUM_COSTS bucket
// cells, one cell per cycle, starting at the low end when smallest_first is
// 1 and at the high end otherwise. busy is high from the cycle after the
// accepting edge until the result strobe. result_valid_o is high for exactly
// one cycle and cannot be held off, so found_o and removed_cost_o must be
// captured in that cycle; a new transaction may be started in that same
// cycle. Write cfg_we_i only while the block is idle.
module bucket_min_max_priority_queue
  import bmmpq_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation_i,
  input  logic [COST_WIDTH-1:0] cost_value_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  output logic                  result_valid_o,
  output logic                  found_o,
  output logic [COST_WIDTH-1:0] removed_cost_o
);

  logic                 smallest_first_q;
  logic                 add_acc;
  logic                 inject;
  logic                 any_hit;
  logic [NUM_COSTS-1:0] tok;
  logic [NUM_COSTS-1:0] hit;
  cell_ctrl_t           ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smallest_first_q <= 1'b1;
    end else if (cfg_we_i) begin
      smallest_first_q <= cfg_wdata_i;
    end
  end

  assign add_acc        = start & ~busy & (operation_i == OP_ADD);
  assign ctrl.low_first = smallest_first_q;
  assign ctrl.scan_en   = busy;
  assign any_hit        = |hit;

  for (genvar i = 0; i < NUM_COSTS; i++) begin : g_cell
    localparam int unsigned CostIdx = i + 1;
    logic tok_lo;
    logic tok_hi;
    logic add_en;

    assign add_en = add_acc & (32'(cost_value_i) == CostIdx);

    // chain ends take the injected token instead of a neighbor
    if (i == 0) begin : g_lo_end
      assign tok_lo = inject;
    end else begin : g_lo_mid
      assign tok_lo = tok[i-1];
    end
    if (i == NUM_COSTS - 1) begin : g_hi_end
      assign tok_hi = inject;
    end else begin : g_hi_mid
      assign tok_hi = tok[i+1];
    end

    bmmpq_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .add_i    (add_en),
      .tok_lo_i (tok_lo),
      .tok_hi_i (tok_hi),
      .tok_o    (tok[i]),
      .hit_o    (hit[i])
    );
  end

  bmmpq_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .operation_i    (operation_i),
    .low_first_i    (smallest_first_q),
    .any_hit_i      (any_hit),
    .busy           (busy),
    .inject_o       (inject),
    .result_valid_o (result_valid_o),
    .found_o        (found_o),
    .removed_cost_o (removed_cost_o)
  );

`ifndef SYNTHESIS
  a_single_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one bucket claimed the token");

  a_single_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok))
    else $error("more than one search token in the chain");

  a_hit_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    any_hit |=> (result_valid_o && found_o && !busy))
    else $error("hit did not produce a found result");
`endif

endmodule

### bench/tb_bucket_min_max_priority_queue.sv
// testbench for the bucketed min/max priority queue: queued stimulus, driver, predictor and checker
`timescale 1ns / 100ps

module tb_bucket_min_max_priority_queue;
  import bmmpq_pkg::*;

  typedef enum logic [1:0] {
    REQ_ITEM,
    REQ_POLICY,
    REQ_SETTLE
  } req_kind_e;

  typedef struct packed {
    req_kind_e             kind;
    op_e                   op;
    logic [COST_WIDTH-1:0] cost;
    logic                  policy;
    logic                  rush;
  } req_t;

  typedef struct packed {
    logic                  found;
    logic [COST_WIDTH-1:0] cost;
  } removal_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic                  operation_i;
  logic [COST_WIDTH-1:0] cost_value_i;
  logic                  cfg_we_i;
  logic                  cfg_wdata_i;
  logic                  result_valid_o;
  logic                  found_o;
  logic [COST_WIDTH-1:0] removed_cost_o;

  req_t     pending_reqs[$];
  removal_t expected_removals[$];

  // predictor state
  logic [COUNT_WIDTH-1:0] bucket_cnt [1:NUM_COSTS];
  logic                   low_first_q;

  logic        took_item;
  int unsigned quiet_cnt;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned err_cnt;

  bucket_min_max_priority_queue DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .operation_i   (operation_i),
    .cost_value_i  (cost_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .found_o       (found_o),
    .removed_cost_o(removed_cost_o)
  );

  always #6 clk_i = ~clk_i;

  task automatic flag_mismatch(input string field, input int unsigned exp_v,
                               input int unsigned act_v);
    err_cnt++;
    $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
  endtask

  task automatic push_item(input op_e op, input int unsigned cost, input logic rush = 1'b0);
    req_t r;
    r.kind   = REQ_ITEM;
    r.op     = op;
    r.cost   = COST_WIDTH'(cost);
    r.policy = 1'b0;
    r.rush   = rush;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_policy(input logic low_first);
    req_t r;
    r        = '0;
    r.kind   = REQ_POLICY;
    r.policy = low_first;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_settle();
    req_t r;
    r      = '0;
    r.kind = REQ_SETTLE;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // pulls one item out of the lowest or highest occupied bucket
  function automatic removal_t take_extreme_cost();
    removal_t    r;
    int unsigned c;
    int unsigned hit;
    r   = '0;
    hit = 0;
    for (int i = 0; i < NUM_COSTS; i++) begin
      c = low_first_q ? i + 1 : NUM_COSTS - i;
      if (hit == 0 && bucket_cnt[c] != '0) hit = c;
    end
    if (hit != 0) begin
      bucket_cnt[hit] = bucket_cnt[hit] - COUNT_WIDTH'(1);
      r.found = 1'b1;
      r.cost  = COST_WIDTH'(hit);
    end
    return r;
  endfunction

  // checker and predictor
  always @(posedge clk_i) begin : monitor
    removal_t exp_r;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (expected_removals.size() == 0) begin
          err_cnt++;
          $error("unexpected result: found %0d removed_cost %0d",
                 found_o, removed_cost_o);
        end else begin
          exp_r = expected_removals.pop_front();
          if (found_o !== exp_r.found) flag_mismatch("found", exp_r.found, found_o);
          if (removed_cost_o !== exp_r.cost) flag_mismatch("removed_cost", exp_r.cost, removed_cost_o);
        end
      end
      if (cfg_we_i) low_first_q = cfg_wdata_i;
      took_item = start && !busy;
      if (took_item) begin
        if (operation_i == OP_ADD) begin
          // out-of-range costs are dropped, full buckets saturate
          if (cost_value_i >= 1 && cost_value_i <= NUM_COSTS &&
              bucket_cnt[cost_value_i] != '1) begin
            bucket_cnt[cost_value_i] = bucket_cnt[cost_value_i] + COUNT_WIDTH'(1);
          end
        end else begin
          exp_r = take_extreme_cost();
          expected_removals.insert(expected_removals.size(), exp_r);
        end
      end
      if (expected_removals.size() == 0 && !busy && !start && !result_valid_o) begin
        quiet_cnt++;
      end else begin
        quiet_cnt = 0;
      end
    end
  end

  // driver: one transaction at a time from the pending queue
  always @(negedge clk_i) begin : driver
    logic nx_start;
    logic nx_we;
    req_t rq;
    nx_start = start;
    nx_we    = 1'b0;
    if (rst_ni) begin
      if (start && took_item) nx_start = 1'b0;
      if (!nx_start && pending_reqs.size() != 0) begin
        rq = pending_reqs[0];
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          case (rq.kind)
            REQ_ITEM: begin
              operation_i  <= rq.op;
              cost_value_i <= rq.cost;
              nx_start      = 1'b1;
              void'(pending_reqs.pop_front());
              if (rq.rush || burst_left != 0) gap_left = 0;
              else gap_left = $urandom_range(0, 9);
              if (burst_left != 0) burst_left--;
              else if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 40);
            end
            REQ_POLICY: begin
              // adds leave no result, so also wait on quiet_cnt before the write
              if (quiet_cnt >= 4) begin
                nx_we = 1'b1;
                cfg_wdata_i <= rq.policy;
                void'(pending_reqs.pop_front());
              end
            end
            default: begin
              if (expected_removals.size() == 0) void'(pending_reqs.pop_front());
            end
          endcase
        end
      end
    end
    start    <= nx_start;
    cfg_we_i <= nx_we;
  end

  initial begin : timeout
    #30_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned add_pct;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    operation_i  = OP_ADD;
    cost_value_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b1;
    took_item    = 1'b0;
    quiet_cnt    = 0;
    gap_left     = 0;
    burst_left   = 0;
    err_cnt      = 0;
    low_first_q  = 1'b1;
    for (int i = 1; i <= NUM_COSTS; i++) bucket_cnt[i] = '0;

    // directed: empty queue, range edges, dropped costs, both policies
    push_item(OP_REMOVE, 0);
    push_item(OP_ADD, 1);
    push_item(OP_ADD, NUM_COSTS);
    push_item(OP_ADD, 0);
    push_item(OP_ADD, 127);
    push_item(OP_ADD, NUM_COSTS + 1);
    push_item(OP_REMOVE, 127);
    push_item(OP_REMOVE, 0);
    push_item(OP_REMOVE, 85);
    push_policy(1'b0);
    push_item(OP_ADD, 5);
    push_item(OP_ADD, 40);
    push_item(OP_ADD, 40);
    push_item(OP_REMOVE, 42);
    push_item(OP_REMOVE, 0);
    push_item(OP_REMOVE, 127);
    push_item(OP_REMOVE, 0);
    push_item(OP_ADD, NUM_COSTS);
    push_item(OP_ADD, 1);
    push_item(OP_REMOVE, 0);
    push_policy(1'b1);
    push_item(OP_REMOVE, 0);

    // back to back: stack cost 1 behind a marker at cost 2, then drain past it
    push_item(OP_ADD, 2, 1'b1);
    for (int i = 0; i < 8; i++) push_item(OP_ADD, 1, 1'b1);
    for (int i = 0; i < 10; i++) push_item(OP_REMOVE, 0, 1'b1);

    // random phases under changing policy and add/remove mix
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 2) push_policy(ph[0] ? 1'b1 : 1'b0);
      else push_policy(1'($urandom_range(0, 1)));
      case (ph % 4)
        0:       add_pct = 60;
        1:       add_pct = 40;
        2:       add_pct = 75;
        default: add_pct = 50;
      endcase
      for (int n = 0; n < 200; n++) begin
        if (n == 100 && (ph == 2 || ph == 5)) push_settle();
        if ($urandom_range(0, 99) < add_pct) begin
          if ($urandom_range(0, 15) == 0) begin
            push_item(OP_ADD, $urandom_range(0, 1) ? 0 : $urandom_range(NUM_COSTS + 1, 127));
          end else begin
            push_item(OP_ADD, $urandom_range(1, NUM_COSTS));
          end
        end else begin
          push_item(OP_REMOVE, $urandom_range(0, 127));
        end
      end
    end

    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_reqs.size() != 0 || start || expected_removals.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (NUM_COSTS + 4) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
rtl/bmmpq_pkg.sv
rtl/bmmpq_cell.sv
rtl/bmmpq_ctrl.sv
rtl/bucket_min_max_priority_queue.sv
bench/tb_bucket_min_max_priority_queue.sv
